@@ rtl/gvai_pkg.sv @@
// Package for the graph vertex/arc insert core: widths, codes, FSM states.
// No dependencies; imported by the interfaces and every module but gvai_ram.
package gvai_pkg;

  // Default vertex table depth
  localparam int DEF_MAX_VERTICES = 128;

  // Payload widths
  localparam int VAL_W = 32;
  localparam int VT_W  = 8;
  localparam int AT_W  = 15;

  // Arc counter saturates here
  localparam logic [AT_W-1:0] ARC_LIMIT = 15'h7FFF;

  // Command codes
  localparam logic CMD_INS_VERTEX = 1'b0;
  localparam logic CMD_INS_ARC    = 1'b1;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ROW_RD,
    ST_ROW_CHK,
    ST_REV_RD,
    ST_REV_WR,
    ST_DONE
  } gvai_state_t;

endpackage

@@ rtl/gvai_in_if.sv @@
// Input channel: valid/ready handshake carrying one command transaction.
// Depends on gvai_pkg for the value width.
interface gvai_in_if import gvai_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic signed [VAL_W-1:0] vertex_value;
  logic signed [VAL_W-1:0] head_value;

  modport source (output valid, command, vertex_value, head_value, input ready);
  modport sink   (input valid, command, vertex_value, head_value, output ready);
endinterface

@@ rtl/gvai_out_if.sv @@
// Result channel: valid/ready handshake carrying one result transaction.
// Depends on gvai_pkg for the count widths.
interface gvai_out_if import gvai_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            success;
  logic [VT_W-1:0] vertex_total;
  logic [AT_W-1:0] arc_total;

  modport source (output valid, success, vertex_total, arc_total, input ready);
  modport sink   (input valid, success, vertex_total, arc_total, output ready);
endinterface

@@ rtl/graph_vertex_arc_insert_core.sv @@
// Graph vertex/arc insert core: vertex value RAM plus adjacency row RAM.
// Time to result grows with N, the stored vertex count, as the scan reads each
// stored vertex; if both ends are found, an arc insert adds a row read and check,
// and for a new undirected arc a reverse row read and write. The next transaction is
// taken in the cycle after the result loads (later while the output is still full).
// Reset (rst_n, synchronous) clears counts, mode, handshakes; rows zeroed on insert.
module graph_vertex_arc_insert_core import gvai_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  gvai_in_if.sink               in_ch,
  gvai_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IDX_W = $clog2(MAX_VERTICES);

  logic                    undirected;
  logic                    vram_we;
  logic [IDX_W-1:0]        vram_addr;
  logic [VAL_W-1:0]        vram_wdata;
  logic [VAL_W-1:0]        vram_rdata;
  logic                    adj_we;
  logic [IDX_W-1:0]        adj_addr;
  logic [MAX_VERTICES-1:0] adj_wdata;
  logic [MAX_VERTICES-1:0] adj_rdata;

  // Configuration register
  gvai_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .undirected (undirected)
  );

  // Vertex value store
  gvai_ram #(.WIDTH(VAL_W), .DEPTH(MAX_VERTICES)) u_vram (
    .clk   (clk),
    .we    (vram_we),
    .addr  (vram_addr),
    .wdata (vram_wdata),
    .rdata (vram_rdata)
  );

  // Adjacency row store
  gvai_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj (
    .clk   (clk),
    .we    (adj_we),
    .addr  (adj_addr),
    .wdata (adj_wdata),
    .rdata (adj_rdata)
  );

  // Sequencer
  gvai_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .undirected (undirected),
    .vram_we    (vram_we),
    .vram_addr  (vram_addr),
    .vram_wdata (vram_wdata),
    .vram_rdata (vram_rdata),
    .adj_we     (adj_we),
    .adj_addr   (adj_addr),
    .adj_wdata  (adj_wdata),
    .adj_rdata  (adj_rdata)
  );

  // One transaction in flight: no accept straight after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while an item is in progress");

  // A new vertex always comes with a cleared adjacency row at the same slot
  a_row_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    vram_we |-> (adj_we && adj_wdata == '0 && adj_addr == vram_addr))
    else $error("vertex stored without clearing its adjacency row");

  // A result only appears while the block is busy with an item
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(!in_ch.ready))
    else $error("result raised without an item in progress");

endmodule

@@ rtl/gvai_ram.sv @@
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module gvai_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read (old data on a write)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/gvai_cfg.sv @@
// APB-style configuration register holding the undirected mode bit.
// Depends on gvai_pkg for the port widths.
module gvai_cfg import gvai_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic                  undirected
);

  logic mode_r;
  logic wr_en;

  // Single word register: the low address bits are the byte offset only
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Hold the mode bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (wr_en) begin
      mode_r <= pwdata[0];
    end
  end

  // Read back the register; every address within the word selects it
  always_comb begin
    prdata    = '0;
    prdata[0] = mode_r;
  end

  assign undirected = mode_r;

endmodule

@@ rtl/gvai_ctrl.sv @@
// Sequencer: scans the vertex RAM, then reads, modifies and writes adjacency
// rows. Holds the counts and the result register. Depends on gvai_pkg and
// the channel interfaces.
module gvai_ctrl import gvai_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  gvai_in_if.sink                          in_ch,
  gvai_out_if.source                       out_ch,
  input  logic                             undirected,
  output logic                             vram_we,
  output logic [$clog2(MAX_VERTICES)-1:0]  vram_addr,
  output logic [VAL_W-1:0]                 vram_wdata,
  input  logic [VAL_W-1:0]                 vram_rdata,
  output logic                             adj_we,
  output logic [$clog2(MAX_VERTICES)-1:0]  adj_addr,
  output logic [MAX_VERTICES-1:0]          adj_wdata,
  input  logic [MAX_VERTICES-1:0]          adj_rdata
);

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);

  gvai_state_t state_r, state_nxt;

  logic             cmd_r, cmd_nxt;
  logic [VAL_W-1:0] tail_r, tail_nxt;
  logic [VAL_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] issue_r, issue_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic             t_fnd_r, t_fnd_nxt;
  logic             h_fnd_r, h_fnd_nxt;
  logic [IDX_W-1:0] t_idx_r, t_idx_nxt;
  logic [IDX_W-1:0] h_idx_r, h_idx_nxt;
  logic             ok_r, ok_nxt;
  logic [CNT_W-1:0] vcnt_r, vcnt_nxt;
  logic [AT_W-1:0]  acnt_r, acnt_nxt;

  logic             ovld_r, ovld_nxt;
  logic             osucc_r, osucc_nxt;
  logic [VT_W-1:0]  ovt_r, ovt_nxt;
  logic [AT_W-1:0]  oat_r, oat_nxt;

  logic [MAX_VERTICES-1:0] bit_t, bit_h;
  logic                    scan_end;

  // One-hot column masks for the two endpoints
  always_comb begin
    bit_t = '0;
    bit_h = '0;
    bit_t[t_idx_r] = 1'b1;
    bit_h[h_idx_r] = 1'b1;
  end

  assign scan_end = (issue_r == vcnt_r) && !cmp_vld_r;

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cmp_vld_r <= 1'b0;
      vcnt_r    <= '0;
      acnt_r    <= '0;
      ovld_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      vcnt_r    <= vcnt_nxt;
      acnt_r    <= acnt_nxt;
      ovld_r    <= ovld_nxt;
    end
  end

  // Payload and scan registers
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    tail_r    <= tail_nxt;
    head_r    <= head_nxt;
    issue_r   <= issue_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    t_fnd_r   <= t_fnd_nxt;
    h_fnd_r   <= h_fnd_nxt;
    t_idx_r   <= t_idx_nxt;
    h_idx_r   <= h_idx_nxt;
    ok_r      <= ok_nxt;
    osucc_r   <= osucc_nxt;
    ovt_r     <= ovt_nxt;
    oat_r     <= oat_nxt;
  end

  // Next state, memory requests and result register
  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    tail_nxt    = tail_r;
    head_nxt    = head_r;
    issue_nxt   = issue_r;
    cmp_vld_nxt = 1'b0;
    cmp_idx_nxt = cmp_idx_r;
    t_fnd_nxt   = t_fnd_r;
    h_fnd_nxt   = h_fnd_r;
    t_idx_nxt   = t_idx_r;
    h_idx_nxt   = h_idx_r;
    ok_nxt      = ok_r;
    vcnt_nxt    = vcnt_r;
    acnt_nxt    = acnt_r;
    ovld_nxt    = ovld_r;
    osucc_nxt   = osucc_r;
    ovt_nxt     = ovt_r;
    oat_nxt     = oat_r;
    vram_we     = 1'b0;
    vram_addr   = issue_r[IDX_W-1:0];
    vram_wdata  = tail_r;
    adj_we      = 1'b0;
    adj_addr    = t_idx_r;
    adj_wdata   = adj_rdata | bit_h;
    in_ch.ready = 1'b0;

    // Drop the result once taken
    if (out_ch.ready) begin
      ovld_nxt = 1'b0;
    end

    // Compare the value returned for the previous scan address
    if (cmp_vld_r) begin
      if (!t_fnd_r && vram_rdata == tail_r) begin
        t_fnd_nxt = 1'b1;
        t_idx_nxt = cmp_idx_r;
      end
      if (!h_fnd_r && vram_rdata == head_r) begin
        h_fnd_nxt = 1'b1;
        h_idx_nxt = cmp_idx_r;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          cmd_nxt   = in_ch.command;
          tail_nxt  = in_ch.vertex_value;
          head_nxt  = in_ch.head_value;
          issue_nxt = '0;
          t_fnd_nxt = 1'b0;
          h_fnd_nxt = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue_r != vcnt_r) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = issue_r[IDX_W-1:0];
          issue_nxt   = issue_r + 1'b1;
        end else if (scan_end) begin
          ok_nxt    = 1'b0;
          state_nxt = ST_DONE;
          if (cmd_r == CMD_INS_VERTEX) begin
            // Append the value and zero its adjacency row
            if (!t_fnd_r && vcnt_r < CNT_MAX) begin
              vram_we   = 1'b1;
              vram_addr = vcnt_r[IDX_W-1:0];
              adj_we    = 1'b1;
              adj_addr  = vcnt_r[IDX_W-1:0];
              adj_wdata = '0;
              vcnt_nxt  = vcnt_r + 1'b1;
              ok_nxt    = 1'b1;
            end
          end else if (t_fnd_r && h_fnd_r) begin
            state_nxt = ST_ROW_RD;
          end
        end
      end
      ST_ROW_RD: begin
        adj_addr  = t_idx_r;
        state_nxt = ST_ROW_CHK;
      end
      ST_ROW_CHK: begin
        adj_addr  = t_idx_r;
        state_nxt = ST_DONE;
        if (!adj_rdata[h_idx_r]) begin
          adj_we    = 1'b1;
          adj_wdata = adj_rdata | bit_h;
          ok_nxt    = 1'b1;
          if (acnt_r < ARC_LIMIT) begin
            acnt_nxt = acnt_r + 1'b1;
          end
          if (undirected) begin
            state_nxt = ST_REV_RD;
          end
        end
      end
      ST_REV_RD: begin
        adj_addr  = h_idx_r;
        state_nxt = ST_REV_WR;
      end
      ST_REV_WR: begin
        adj_addr  = h_idx_r;
        adj_we    = 1'b1;
        adj_wdata = adj_rdata | bit_t;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // Load the result once the output register is free
        if (!ovld_r || out_ch.ready) begin
          ovld_nxt  = 1'b1;
          osucc_nxt = ok_r;
          ovt_nxt   = VT_W'(vcnt_r);
          oat_nxt   = acnt_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_ch.valid        = ovld_r;
  assign out_ch.success      = osucc_r;
  assign out_ch.vertex_total = ovt_r;
  assign out_ch.arc_total    = oat_r;

endmodule

@@ dv/tb_graph_vertex_arc_insert_core.sv @@
`timescale 1ns / 1ps
// Testbench for graph_vertex_arc_insert_core: directed and random vertex/arc inserts,
// checked against a graph predictor held in a small scoreboard class.
// Depends on gvai_pkg, gvai_in_if, gvai_out_if and the core itself.
module tb_graph_vertex_arc_insert_core;
  import gvai_pkg::*;

  localparam int                    WATCHDOG_LIMIT = 4000;
  localparam int                    END_WAIT       = 150;
  localparam int                    PHASE_ITEMS    = 229;
  localparam logic [CFG_ADDR_W-1:0] REG_UNDIRECTED = '0;
  localparam logic [VAL_W-1:0]      VAL_MIN        = 32'h8000_0000;
  localparam logic [VAL_W-1:0]      VAL_MAX        = 32'h7FFF_FFFF;

  // Graph predictor: vertex table, adjacency matrix and counts, plus expected results
  class graph_scoreboard;
    logic [VAL_W-1:0]          vertex_tab [DEF_MAX_VERTICES];
    bit [DEF_MAX_VERTICES-1:0] adj_row [DEF_MAX_VERTICES];
    int unsigned               vertex_cnt;
    int unsigned               arc_cnt;
    bit                        undirected;
    int unsigned               errors;
    logic [VT_W+AT_W:0]        expected_q [$];

    function new();
      vertex_cnt = 0;
      arc_cnt    = 0;
      undirected = 1'b0;
      errors     = 0;
      foreach (adj_row[i]) adj_row[i] = '0;
    endfunction

    // Lowest stored index holding the value, or -1
    function int find_index(logic [VAL_W-1:0] value);
      for (int i = 0; i < vertex_cnt; i++) begin
        if (vertex_tab[i] == value) return i;
      end
      return -1;
    endfunction

    // Work out the result of one accepted transaction and queue it
    function void note_input(logic cmd, logic [VAL_W-1:0] tail_v, logic [VAL_W-1:0] head_v);
      int   t_idx;
      int   h_idx;
      logic ok;
      ok = 1'b0;
      if (cmd == CMD_INS_VERTEX) begin
        if (find_index(tail_v) < 0 && vertex_cnt < DEF_MAX_VERTICES) begin
          vertex_tab[vertex_cnt] = tail_v;
          vertex_cnt++;
          ok = 1'b1;
        end
      end else begin
        t_idx = find_index(tail_v);
        h_idx = find_index(head_v);
        if (t_idx >= 0 && h_idx >= 0 && !adj_row[t_idx][h_idx]) begin
          adj_row[t_idx][h_idx] = 1'b1;
          if (undirected) adj_row[h_idx][t_idx] = 1'b1;
          if (arc_cnt < ARC_LIMIT) arc_cnt++;
          ok = 1'b1;
        end
      end
      expected_q.push_back({ok, VT_W'(vertex_cnt), AT_W'(arc_cnt)});
    endfunction

    // Compare one result transaction with the oldest expectation
    function void check_result(logic success, logic [VT_W-1:0] v_tot, logic [AT_W-1:0] a_tot);
      logic            exp_ok;
      logic [VT_W-1:0] exp_v;
      logic [AT_W-1:0] exp_a;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result success=%0d vertex_total=%0d arc_total=%0d",
                 $time, success, v_tot, a_tot);
        errors++;
        return;
      end
      {exp_ok, exp_v, exp_a} = expected_q.pop_front();
      if (success !== exp_ok) begin
        $display("%0t: success expected %0d actual %0d", $time, exp_ok, success);
        errors++;
      end
      if (v_tot !== exp_v) begin
        $display("%0t: vertex_total expected %0d actual %0d", $time, exp_v, v_tot);
        errors++;
      end
      if (a_tot !== exp_a) begin
        $display("%0t: arc_total expected %0d actual %0d", $time, exp_a, a_tot);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  int unsigned           sender_idle_pct;
  int unsigned           receiver_stall_pct;
  int unsigned           quiet_cycles;
  graph_scoreboard       sb = new();

  gvai_in_if  in_ch ();
  gvai_out_if out_ch ();

  graph_vertex_arc_insert_core DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Check accepted results, then draw the next ready
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.success, out_ch.vertex_total, out_ch.arc_total);
    end
    out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Watchdog: end the run after too long without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Offer one transaction, idling first at random; valid stays high after acceptance
  task automatic send_item(logic cmd, logic [VAL_W-1:0] tail_v, logic [VAL_W-1:0] head_v);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= cmd;
    in_ch.vertex_value <= tail_v;
    in_ch.head_value   <= head_v;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(cmd, tail_v, head_v);
  endtask

  // Hold until every expected result has come back
  task automatic wait_idle();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the mode register through the APB port: setup, then access
  task automatic write_mode(bit mode);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_UNDIRECTED;
    pwdata  <= {{(CFG_DATA_W-1){1'b0}}, mode};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.undirected = mode;
  endtask

  function automatic logic [VAL_W-1:0] random_value();
    case ($urandom_range(19))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return VAL_W'($urandom_range(15));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] stored_value();
    if (sb.vertex_cnt == 0) return random_value();
    return sb.vertex_tab[$urandom_range(sb.vertex_cnt - 1)];
  endfunction

  // Mostly arcs between stored vertices, some fresh and duplicate vertices, some misses
  task automatic random_item();
    int unsigned      pick;
    logic [VAL_W-1:0] a_val;
    logic [VAL_W-1:0] b_val;
    pick  = $urandom_range(99);
    a_val = random_value();
    b_val = random_value();
    if (pick < 25) begin
      send_item(CMD_INS_VERTEX, a_val, b_val);
    end else if (pick < 30) begin
      send_item(CMD_INS_VERTEX, stored_value(), b_val);
    end else if (pick < 90) begin
      a_val = stored_value();
      b_val = ($urandom_range(9) == 0) ? a_val : stored_value();
      send_item(CMD_INS_ARC, a_val, b_val);
    end else if (pick < 95) begin
      send_item(CMD_INS_ARC, stored_value(), a_val);
    end else begin
      send_item(CMD_INS_ARC, a_val, stored_value());
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.command      = CMD_INS_VERTEX;
    in_ch.vertex_value = '0;
    in_ch.head_value   = '0;
    out_ch.ready       = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    quiet_cycles       = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed graph: empty lookups, value extremes, duplicates, misses, self loops
    write_mode(1'b0);
    send_item(CMD_INS_ARC, 32'd5, 32'd6);
    send_item(CMD_INS_VERTEX, VAL_MIN, '0);
    send_item(CMD_INS_VERTEX, VAL_MAX, '1);
    send_item(CMD_INS_VERTEX, '0, 32'hDEAD_BEEF);
    send_item(CMD_INS_VERTEX, '1, VAL_MIN);
    send_item(CMD_INS_VERTEX, VAL_MAX, '0);
    send_item(CMD_INS_ARC, VAL_MIN, VAL_MAX);
    send_item(CMD_INS_ARC, VAL_MIN, VAL_MAX);
    send_item(CMD_INS_ARC, VAL_MAX, VAL_MIN);
    send_item(CMD_INS_ARC, 32'd12345, '0);
    send_item(CMD_INS_ARC, '0, 32'd12345);
    send_item(CMD_INS_ARC, '0, '0);
    send_item(CMD_INS_ARC, '0, '0);
    send_item(CMD_INS_VERTEX, 32'd7, 32'h5555_AAAA);
    send_item(CMD_INS_ARC, 32'd7, '0);
    in_ch.valid <= 1'b0;
    wait_idle();

    // Undirected graph: both directions set, reverse arc already present, self loop
    write_mode(1'b1);
    send_item(CMD_INS_ARC, '0, '1);
    send_item(CMD_INS_ARC, '1, '0);
    send_item(CMD_INS_ARC, '0, 32'd7);
    send_item(CMD_INS_ARC, 32'd7, '0);
    send_item(CMD_INS_ARC, '1, '1);
    send_item(CMD_INS_ARC, VAL_MIN, VAL_MAX);
    in_ch.valid <= 1'b0;
    wait_idle();

    // Random phases: each idling profile in both modes
    for (int phase = 0; phase < 8; phase++) begin
      case (phase / 2)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 63; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 63; end
        default: begin sender_idle_pct = 12; receiver_stall_pct = 12; end
      endcase
      write_mode(phase[0]);
      repeat (PHASE_ITEMS) random_item();
      in_ch.valid <= 1'b0;
      wait_idle();
    end

    repeat (END_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

@@ graph_vertex_arc_insert_core.f @@
rtl/gvai_pkg.sv
rtl/gvai_in_if.sv
rtl/gvai_out_if.sv
rtl/gvai_ram.sv
rtl/gvai_cfg.sv
rtl/gvai_ctrl.sv
rtl/graph_vertex_arc_insert_core.sv
dv/tb_graph_vertex_arc_insert_core.sv
